// File: rtl/pprl_pkg.sv
// ----------------------------------------------------------------------------
// pprl_pkg: shared types and constants of the per-peer reply rate limiter
// Field widths, verdict codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package pprl_pkg;

	localparam int NODE_W   = 32;
	localparam int TIME_W   = 48;
	localparam int IVAL_W   = 32;
	localparam int SLOTF_W  = 2;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;

	typedef logic [NODE_W-1:0]    node_t;
	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [SLOTF_W-1:0]   slot_field_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

	typedef enum logic [1:0] {
		VERDICT_ALLOW      = 2'd0,
		VERDICT_BAD_SENDER = 2'd1,
		VERDICT_NOT_ENV    = 2'd2,
		VERDICT_SUPPRESS   = 2'd3
	} verdict_t;

	localparam cfg_idx_t REG_OWN_NODE_ID       = 8'd0;
	localparam cfg_idx_t REG_SUPPRESS_INTERVAL = 8'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/pprl_if.sv
// ----------------------------------------------------------------------------
// pprl_if: channel interfaces of the rate limiter
// Request, response and configuration-write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface pprl_req_if;
	import pprl_pkg::*;
	logic  valid;
	logic  ready;
	node_t sender_node;
	time_t now_ms;
	logic  is_env_request;
	modport source (output valid, sender_node, now_ms, is_env_request, input ready);
	modport sink   (input valid, sender_node, now_ms, is_env_request, output ready);
endinterface

interface pprl_rsp_if;
	import pprl_pkg::*;
	logic        valid;
	logic        ready;
	verdict_t    verdict;
	slot_field_t slot_used;
	modport source (output valid, verdict, slot_used, input ready);
	modport sink   (input valid, verdict, slot_used, output ready);
endinterface

interface pprl_cfg_if;
	import pprl_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cfg_dat_t data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/per_peer_reply_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// per_peer_reply_rate_limiter_unit: per-peer reply rate limiter
// Screens telemetry requests and rate-limits replies per peer slot.
// ----------------------------------------------------------------------------
// An early rejection goes from IDLE straight to EMIT; a screened request
//   passes SCAN, which checks slots until a match, a free slot or the table
//   end, then DECIDE and EMIT. EMIT loads the output register once it is free.
// A new request is taken only in IDLE, after the last one is emitted; the
//   peer table RAM has one read port and one slot is scanned per cycle.
// Reset: arst_n clears the configuration registers, slot valid bits, output valid and the controller at once.
module per_peer_reply_rate_limiter_unit #(
	parameter int PEER_SLOTS = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	pprl_req_if.sink   req,
	pprl_rsp_if.source rsp,
	pprl_cfg_if.sink   cfg
);
	import pprl_pkg::*;

	localparam int SLOT_W  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int ENTRY_W = NODE_W + TIME_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PEER_SLOTS - 1);

	typedef logic [SLOT_W-1:0] slot_t;

	// Configuration registers. The user must write them only while idle; the block itself does not enforce it.
	node_t               own_node_q;
	logic [IVAL_W-1:0]   interval_q;

	// Controller
	state_t state_q, state_d;

	// Current request
	node_t who_q;
	time_t now_q;

	// Scan bookkeeping: chk_idx_q is the slot whose RAM data is on rdata.
	slot_t chk_idx_q;
	slot_t oldest_idx_q;
	time_t oldest_t_q;
	slot_t chosen_q;
	logic  chosen_valid_q;
	time_t chosen_t_q;

	// One bit per slot: stamped at least once. A clear slot is free, and its
	// RAM entry is never trusted.
	logic [PEER_SLOTS-1:0] valid_q;

	// Pending result and output register
	verdict_t    res_verdict_q;
	slot_field_t res_slot_q;
	logic        out_valid_q;
	verdict_t    out_verdict_q;
	slot_field_t out_slot_q;

	// RAM ports
	logic                ram_we;
	slot_t               ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	pprl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PEER_SLOTS)
	) u_peer_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(chosen_q),
		.wdata({who_q, now_q}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------- screen
	logic req_fire;
	logic bad_sender;
	assign req_fire   = req.valid && req.ready;
	assign bad_sender = (req.sender_node == '0) || (req.sender_node == own_node_q);

	// ------------------------------------------------------------------ scan
	node_t rd_node;
	time_t rd_time;
	logic  slot_valid;
	logic  hit;
	logic  older;
	logic  at_last;
	slot_t cand_idx;
	time_t cand_t;

	assign rd_node    = ram_rdata[ENTRY_W-1:TIME_W];
	assign rd_time    = ram_rdata[TIME_W-1:0];
	assign slot_valid = valid_q[chk_idx_q];
	// Free slot claims the sender; a stamped slot must hold the sender.
	assign hit        = !slot_valid || (rd_node == who_q);
	// Strict less-than keeps the lowest index on equal times.
	assign older      = (chk_idx_q == '0) || (rd_time < oldest_t_q);
	assign cand_idx   = older ? chk_idx_q : oldest_idx_q;
	assign cand_t     = older ? rd_time : oldest_t_q;
	assign at_last    = (chk_idx_q == LAST_SLOT);

	// ---------------------------------------------------------------- decide
	// Signed difference of two 48-bit times; negative never counts as elapsed.
	logic [TIME_W:0] diff;
	logic            elapsed;
	assign diff    = {1'b0, now_q} - {1'b0, chosen_t_q};
	assign elapsed = !chosen_valid_q ||
		(!diff[TIME_W] && (diff[TIME_W-1:0] >= TIME_W'(interval_q)));

	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (bad_sender || !req.is_env_request) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit || at_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// --------------------------------------------------------------- outputs
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				ram_raddr = '0;
			end
			ST_SCAN: begin
				// Prefetch the next slot; a read past the last slot is a dead read.
				ram_raddr = chk_idx_q + slot_t'(1);
			end
			ST_DECIDE: begin
				ram_we = elapsed;
			end
			ST_EMIT: begin
				ram_raddr = '0;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	assign cfg.ready     = 1'b1;
	assign rsp.valid     = out_valid_q;
	assign rsp.verdict   = out_verdict_q;
	assign rsp.slot_used = out_slot_q;

	// ------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			own_node_q  <= '0;
			interval_q  <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_OWN_NODE_ID) begin
					own_node_q <= cfg.data;
				end else if (cfg.index == REG_SUPPRESS_INTERVAL) begin
					interval_q <= cfg.data;
				end
			end
			if (state_q == ST_DECIDE && elapsed) begin
				valid_q[chosen_q] <= 1'b1;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------ datapath registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			who_q     <= req.sender_node;
			now_q     <= req.now_ms;
			chk_idx_q <= '0;
			res_slot_q <= '0;
			if (bad_sender) begin
				res_verdict_q <= VERDICT_BAD_SENDER;
			end else begin
				res_verdict_q <= VERDICT_NOT_ENV;
			end
		end
		if (state_q == ST_SCAN) begin
			oldest_idx_q <= cand_idx;
			oldest_t_q   <= cand_t;
			if (hit) begin
				chosen_q       <= chk_idx_q;
				chosen_valid_q <= slot_valid;
				chosen_t_q     <= rd_time;
			end else if (at_last) begin
				// Eviction: the slot is reclaimed, so its old stamp is void.
				chosen_q       <= cand_idx;
				chosen_valid_q <= 1'b0;
				chosen_t_q     <= cand_t;
			end else begin
				chk_idx_q <= chk_idx_q + slot_t'(1);
			end
		end
		if (state_q == ST_DECIDE) begin
			res_verdict_q <= elapsed ? VERDICT_ALLOW : VERDICT_SUPPRESS;
			res_slot_q    <= SLOTF_W'(chosen_q);
		end
		if (emit_go) begin
			out_verdict_q <= res_verdict_q;
			out_slot_q    <= res_slot_q;
		end
	end
endmodule

// File: rtl/pprl_ram.sv
// ----------------------------------------------------------------------------
// pprl_ram: generic single-write, single-read RAM
// One write port, one read port with the read data registered.
// ----------------------------------------------------------------------------
module pprl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/pprl_checker.sv
// ----------------------------------------------------------------------------
// pprl_checker: port-level assertions for the rate limiter
// Watches request and response transactions on the top-level ports.
// ----------------------------------------------------------------------------
module pprl_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input pprl_pkg::verdict_t    rsp_verdict,
	input pprl_pkg::slot_field_t rsp_slot_used
);
	import pprl_pkg::*;

	logic       req_fire;
	logic       rsp_fire;
	logic [1:0] pending_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// Requests taken but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_fire) - 2'(rsp_fire);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
			$stable(rsp_slot_used))
		else $error("response changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without a pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests in flight");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("new request taken before the last one finished");

	a_reject_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_verdict == VERDICT_BAD_SENDER ||
			rsp_verdict == VERDICT_NOT_ENV) |-> rsp_slot_used == '0)
		else $error("early rejection reports a slot");
endmodule

bind per_peer_reply_rate_limiter_unit pprl_checker u_pprl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_verdict  (rsp.verdict),
	.rsp_slot_used(rsp.slot_used)
);
